>>> src/assert_macros.svh
// Assertion helpers used by cubic_curve_arc_sampler.sv. Both expect clk and rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define CCAS_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication.
`define CCAS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> src/ccas_pkg.sv
package ccas_pkg;

  localparam int UNIT_STEPS = 56;

  typedef enum logic [1:0] {
    OP_MUL,
    OP_SQRT,
    OP_DIV
  } op_t;

  typedef struct packed {
    logic start;
    op_t  op;
  } unit_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

endpackage

>>> src/ccas_unit.sv
module ccas_unit import ccas_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  unit_req_t    req,
  input  logic [111:0] a,
  input  logic [63:0]  b,
  output unit_stat_t   st,
  output logic [119:0] res
);

  localparam logic [5:0] LastStep = 6'(UNIT_STEPS - 1);

  logic         busy;
  logic         done;
  logic [5:0]   cnt;
  op_t          op_r;
  logic [119:0] prod;
  logic [63:0]  mcand;
  logic [111:0] shreg;
  logic [57:0]  rem;
  logic [55:0]  root;
  logic [55:0]  dvs;

  logic [64:0]  sum65;
  logic [59:0]  remx;
  logic [59:0]  trial;
  logic [59:0]  diff;
  logic         ge;

  always_comb begin
    sum65 = {1'b0, prod[119:56]} + (prod[0] ? {1'b0, mcand} : 65'd0);
    if (op_r == OP_SQRT) begin
      remx  = {rem, shreg[111:110]};
      trial = {2'b00, root, 2'b01};
    end else begin
      remx  = {1'b0, rem, shreg[111]};
      trial = {4'b0000, dvs};
    end
    ge   = remx >= trial;
    diff = remx - trial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy  <= 1'b1;
        cnt   <= '0;
        op_r  <= req.op;
        prod  <= {64'd0, a[55:0]};
        mcand <= b;
        shreg <= (req.op == OP_DIV) ? {a[55:0], 56'd0} : a;
        rem   <= '0;
        root  <= '0;
        dvs   <= b[55:0];
      end else if (busy) begin
        case (op_r)
          OP_MUL: begin
            prod <= {sum65, prod[55:1]};
          end
          OP_SQRT: begin
            rem   <= ge ? diff[57:0] : remx[57:0];
            root  <= {root[54:0], ge};
            shreg <= {shreg[109:0], 2'b00};
          end
          OP_DIV: begin
            rem   <= ge ? diff[57:0] : remx[57:0];
            root  <= {root[54:0], ge};
            shreg <= {shreg[110:0], 1'b0};
          end
          default: begin
            prod <= prod;
          end
        endcase
        cnt <= cnt + 6'd1;
        if (cnt == LastStep) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign st.busy = busy;
  assign st.done = done;
  assign res     = (op_r == OP_MUL) ? prod : {64'd0, root};

endmodule

>>> src/cubic_curve_arc_sampler.sv
// Cubic lane-curve sampler.
// The input channel (s_axis) takes one word per curve: the four coefficients, the two
// span ends in either order, the step factor and the length limit. The output channel
// (m_axis) returns the sample points of that curve in walk order, one word each, with
// tlast on the final one. A curve whose length limit is zero gives one word with the
// point flag low and tlast high. A curve that runs into the point count limit marks
// its final word with the truncated flag.
// All multiplies, square roots and divides run through one shared unit that does each
// in 56 steps; a multiply whose product is scaled and clamped then passes through
// S_MPOST. The first point of a curve needs eight operations, and every later point
// adds the chord (eleven operations). A curve with a zero length limit passes through
// S_EMPTY and gives its word once the output register is free. s_axis_tready is high
// only between curves.
// The output word sits in a register; a stalled receiver halts the walk at the next
// point until the word is taken, and the next curve may be accepted while the final
// word of the previous one still waits.
// Reset (rst, synchronous) empties the output register and returns to idle.
module cubic_curve_arc_sampler import ccas_pkg::*; #(
  parameter int MAX_POINTS = 64
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // coef_cubic, coef_quad, coef_lin, coef_const, x_begin, x_finish, step_factor,
  // length_limit, two zero bits
  input  logic [287:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // point_x, point_y, length_so_far
  output logic [95:0]  m_axis_tdata,
  // point_valid, truncated
  output logic [1:0]   m_axis_tuser,
  output logic         m_axis_tlast
);

`include "assert_macros.svh"

  localparam logic [6:0]  MaxCnt   = 7'(MAX_POINTS);
  localparam logic [62:0] MagClamp = {1'b1, 62'd0};
  localparam logic signed [63:0] SlopeHi = 64'sd36028797018963968;
  localparam logic signed [63:0] SlopeLo = -64'sd36028797018963968;
  localparam logic signed [63:0] YHi = 64'sd2147483647;
  localparam logic signed [63:0] YLo = -64'sd2147483648;

  typedef enum logic [4:0] {
    S_IDLE, S_EMPTY, S_MWAIT, S_MPOST,
    S_Y1, S_Y1A, S_Y2, S_Y2A, S_Y3, S_Y3A,
    S_DX, S_DY, S_CH, S_ACC,
    S_S1, S_S1A, S_S2, S_S2A, S_SQ, S_SQA, S_DV, S_STEP,
    S_DEC, S_EMIT
  } state_t;

  state_t state, ret;
  logic   post, neg;

  logic signed [47:0] c3, c2;
  logic signed [31:0] c1, c0, x_end;
  logic [30:0]        factor, limit;
  logic signed [33:0] walk_x;
  logic signed [31:0] prev_x, prev_y, ycur;
  logic [31:0]        run_len;
  logic [6:0]         count;
  logic signed [63:0] h;
  logic [62:0]        term;
  logic [66:0]        sq;
  logic [31:0]        pend_x, pend_y, pend_len;
  logic               cont, trunc_f;

  logic               out_valid;
  logic [95:0]        out_data;
  logic [1:0]         out_user;
  logic               out_last;

  unit_req_t    ureq;
  unit_stat_t   ust;
  logic [111:0] ua;
  logic [63:0]  ub;
  logic [119:0] ures;

  // Combinational helpers.
  logic signed [31:0] in_xa, in_xb;
  logic [31:0]        x_mag;
  logic [47:0]        c3_mag;
  logic signed [49:0] c3x3;
  logic [49:0]        c3x3_mag;
  logic [63:0]        h_mag;
  logic [95:0]        qr;
  logic signed [63:0] sterm;
  logic signed [63:0] ysum, ssum;
  logic [33:0]        dx;
  logic signed [32:0] dy;
  logic [32:0]        dy_mag;
  logic [33:0]        chord;
  logic [34:0]        lensum;
  logic [30:0]        step;
  logic               slot_free;
  logic               load_out;

  always_comb begin
    in_xa    = s_axis_tdata[191:160];
    in_xb    = s_axis_tdata[223:192];
    x_mag    = walk_x[33] ? 32'(-walk_x) : walk_x[31:0];
    c3_mag   = c3[47] ? -c3 : c3;
    c3x3     = {{2{c3[47]}}, c3} + {c3[47], c3, 1'b0};
    c3x3_mag = c3x3[49] ? -c3x3 : c3x3;
    h_mag    = h[63] ? -h : h;
    qr       = ures[119:24] + {95'd0, (neg && (ures[23:0] != 24'd0))};
    sterm    = neg ? -$signed({1'b0, term}) : $signed({1'b0, term});
    ysum     = sterm + {{32{c0[31]}}, c0};
    ssum     = sterm + {{32{c1[31]}}, c1};
    dx       = walk_x - {{2{prev_x[31]}}, prev_x};
    dy       = {ycur[31], ycur} - {prev_y[31], prev_y};
    dy_mag   = dy[32] ? 33'(-dy) : dy;
    chord    = (count == 7'd0) ? 34'd0 : ures[33:0];
    lensum   = {3'b000, run_len} + {1'b0, chord};
    step     = (ures[30:0] == 31'd0) ? 31'd1 : ures[30:0];
    slot_free = !out_valid || m_axis_tready;
    load_out  = ((state == S_EMPTY) || (state == S_EMIT)) && slot_free;
  end

  // Operand selection for the shared unit.
  always_comb begin
    ureq.start = 1'b0;
    ureq.op    = OP_MUL;
    ua         = '0;
    ub         = '0;
    case (state)
      S_Y1: begin
        ureq.start = 1'b1;
        ua = {80'd0, x_mag};
        ub = {16'd0, c3_mag};
      end
      S_Y2, S_Y3, S_S2: begin
        ureq.start = 1'b1;
        ua = {80'd0, x_mag};
        ub = h_mag;
      end
      S_S1: begin
        ureq.start = 1'b1;
        ua = {80'd0, x_mag};
        ub = {14'd0, c3x3_mag};
      end
      S_DX: begin
        ureq.start = 1'b1;
        ua = {79'd0, dx[32:0]};
        ub = {31'd0, dx[32:0]};
      end
      S_DY: begin
        ureq.start = 1'b1;
        ua = {79'd0, dy_mag};
        ub = {31'd0, dy_mag};
      end
      S_CH: begin
        ureq.start = 1'b1;
        ureq.op    = OP_SQRT;
        ua = {45'd0, sq + ures[66:0]};
      end
      S_SQ: begin
        ureq.start = 1'b1;
        ua = {56'd0, h_mag[55:0]};
        ub = h_mag;
      end
      S_SQA: begin
        ureq.start = 1'b1;
        ureq.op    = OP_SQRT;
        ua = {1'b0, ures[110:0]} + (112'd1 << 48);
      end
      S_DV: begin
        ureq.start = 1'b1;
        ureq.op    = OP_DIV;
        ua = {56'd0, 1'b0, factor, 24'd0};
        ub = {8'd0, ures[55:0]};
      end
      default: begin
        ureq.start = 1'b0;
      end
    endcase
  end

  ccas_unit u_unit (
    .clk (clk),
    .rst (rst),
    .req (ureq),
    .a   (ua),
    .b   (ub),
    .st  (ust),
    .res (ures)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      ret       <= S_IDLE;
      post      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && m_axis_tready && !load_out) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            c3     <= s_axis_tdata[47:0];
            c2     <= s_axis_tdata[95:48];
            c1     <= s_axis_tdata[127:96];
            c0     <= s_axis_tdata[159:128];
            factor <= s_axis_tdata[254:224];
            limit  <= s_axis_tdata[285:255];
            if (in_xa < in_xb) begin
              walk_x <= {{2{in_xa[31]}}, in_xa};
              prev_x <= in_xa;
              x_end  <= in_xb;
            end else begin
              walk_x <= {{2{in_xb[31]}}, in_xb};
              prev_x <= in_xb;
              x_end  <= in_xa;
            end
            run_len <= '0;
            count   <= '0;
            state   <= (s_axis_tdata[285:255] == 31'd0) ? S_EMPTY : S_Y1;
          end
        end
        S_EMPTY: begin
          if (slot_free) begin
            out_valid <= 1'b1;
            out_data  <= '0;
            out_user  <= 2'b00;
            out_last  <= 1'b1;
            state     <= S_IDLE;
          end
        end
        S_MWAIT: begin
          if (ust.done) begin
            state <= post ? S_MPOST : ret;
          end
        end
        S_MPOST: begin
          term  <= (qr > {33'd0, MagClamp}) ? MagClamp : qr[62:0];
          state <= ret;
        end
        S_Y1: begin
          neg <= c3[47] ^ walk_x[33];
          post <= 1'b1; ret <= S_Y1A; state <= S_MWAIT;
        end
        S_Y1A: begin
          h     <= sterm + {{16{c2[47]}}, c2};
          state <= S_Y2;
        end
        S_Y2: begin
          neg <= h[63] ^ walk_x[33];
          post <= 1'b1; ret <= S_Y2A; state <= S_MWAIT;
        end
        S_Y2A: begin
          h     <= sterm + {{32{c1[31]}}, c1};
          state <= S_Y3;
        end
        S_Y3: begin
          neg <= h[63] ^ walk_x[33];
          post <= 1'b1; ret <= S_Y3A; state <= S_MWAIT;
        end
        S_Y3A: begin
          if (ysum > YHi) begin
            ycur <= 32'h7FFF_FFFF;
          end else if (ysum < YLo) begin
            ycur <= 32'h8000_0000;
          end else begin
            ycur <= ysum[31:0];
          end
          // The first point has no chord to measure.
          state <= (count == 7'd0) ? S_ACC : S_DX;
        end
        S_DX: begin
          post <= 1'b0; ret <= S_DY; state <= S_MWAIT;
        end
        S_DY: begin
          sq   <= ures[66:0];
          post <= 1'b0; ret <= S_CH; state <= S_MWAIT;
        end
        S_CH: begin
          post <= 1'b0; ret <= S_ACC; state <= S_MWAIT;
        end
        S_ACC: begin
          run_len  <= (lensum[34:32] != 3'd0) ? 32'hFFFF_FFFF : lensum[31:0];
          pend_len <= (lensum[34:32] != 3'd0) ? 32'hFFFF_FFFF : lensum[31:0];
          pend_x   <= walk_x[31:0];
          pend_y   <= ycur;
          prev_x   <= walk_x[31:0];
          prev_y   <= ycur;
          count    <= count + 7'd1;
          state    <= S_S1;
        end
        S_S1: begin
          neg <= c3x3[49] ^ walk_x[33];
          post <= 1'b1; ret <= S_S1A; state <= S_MWAIT;
        end
        S_S1A: begin
          h     <= sterm + {{15{c2[47]}}, c2, 1'b0};
          state <= S_S2;
        end
        S_S2: begin
          neg <= h[63] ^ walk_x[33];
          post <= 1'b1; ret <= S_S2A; state <= S_MWAIT;
        end
        S_S2A: begin
          if (ssum > SlopeHi) begin
            h <= SlopeHi;
          end else if (ssum < SlopeLo) begin
            h <= SlopeLo;
          end else begin
            h <= ssum;
          end
          state <= S_SQ;
        end
        S_SQ: begin
          post <= 1'b0; ret <= S_SQA; state <= S_MWAIT;
        end
        S_SQA: begin
          post <= 1'b0; ret <= S_DV; state <= S_MWAIT;
        end
        S_DV: begin
          post <= 1'b0; ret <= S_STEP; state <= S_MWAIT;
        end
        S_STEP: begin
          walk_x <= walk_x + {3'b000, step};
          state  <= S_DEC;
        end
        S_DEC: begin
          // The length check comes before the count check.
          cont <= (walk_x <= $signed({{2{x_end[31]}}, x_end})) &&
                  (run_len < {1'b0, limit}) && (count < MaxCnt);
          trunc_f <= (walk_x <= $signed({{2{x_end[31]}}, x_end})) &&
                     (run_len < {1'b0, limit}) && !(count < MaxCnt);
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (slot_free) begin
            out_valid <= 1'b1;
            out_data  <= {pend_len, pend_y, pend_x};
            out_user  <= {trunc_f, 1'b1};
            out_last  <= !cont;
            state     <= cont ? S_Y1 : S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign s_axis_tready = (state == S_IDLE);
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;
  assign m_axis_tuser  = out_user;
  assign m_axis_tlast  = out_last;

  `CCAS_ASSERT_IMPL(a_idle_unit_quiet, s_axis_tready, !ust.busy)
  `CCAS_ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready)
  `CCAS_ASSERT_IMPL(a_empty_word_zero, m_axis_tvalid && !m_axis_tuser[0],
                    m_axis_tlast && !m_axis_tuser[1] && (m_axis_tdata == 96'd0))
  `CCAS_ASSERT_IMPL(a_trunc_is_last, m_axis_tvalid && m_axis_tuser[1], m_axis_tlast)
  `CCAS_ASSERT_IMPL(a_count_bound, state != S_IDLE, count <= MaxCnt)

endmodule
